FILE: rtl/core/dssg_pkg.sv
// ----------------------------------------------------------------------------
// dssg_pkg
// Shared widths and fixed constants of the decaying sine shake generator.
// ----------------------------------------------------------------------------
package dssg_pkg;

    // serial multiplier: multiplicand width, multiplier width (one bit a cycle)
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // serial divider: dividend width (one quotient bit a cycle), divisor width
    localparam int DIV_N_W = 34;
    localparam int DIV_D_W = 17;

    // request kinds
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    localparam logic [16:0] AGE_MAX = 17'd131071;
    localparam logic [DIV_D_W-1:0] MS_PER_S = 17'd1000;

    // quarter-wave polynomial coefficients, Q2.30
    localparam logic [31:0] Q30_ONE = 32'd1073741824;
    localparam logic [31:0] C1      = 32'd1686629713;
    localparam logic [31:0] C3      = 32'd693598668;
    localparam logic [31:0] C5      = 32'd85569305;
    localparam logic [31:0] C7      = 32'd5026995;
    localparam logic [31:0] C9      = 32'd172272;

endpackage

FILE: rtl/core/decaying_sine_shake_generator.sv
// ----------------------------------------------------------------------------
// decaying_sine_shake_generator
// A trigger request starts a shake (peak in Q8.8, length in ms, frequency in
// Hz); the length is cut to whole periods. Each tick request during a shake
// advances the age and returns peak * sin(2*pi*f*age/1000) * (1 - age/length)
// as signed Q8.8, or zero once the shake is over. Every request gives exactly
// one result. Work is done on one request at a time by a shared bit-serial
// multiplier and a bit-serial divider.
// A tick during a shake takes 9 products and 3 quotients; a started trigger
// takes 2 of each; an ignored trigger or a tick with no shake takes none.
// The result sits in an output register, so a new request is taken while the
// previous result is still waiting.
// ----------------------------------------------------------------------------
module decaying_sine_shake_generator
    import dssg_pkg::*;
#(
    parameter int SINE_PHASE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [9:0]  i_delta_ms,
    input  logic [15:0] i_amplitude,
    input  logic [15:0] i_duration_ms,
    input  logic [7:0]  i_frequency_hz,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [16:0] o_offset,
    output logic        o_active,
    output logic        o_accepted
);

    localparam int QB      = SINE_PHASE_BITS - 2;
    localparam int T_W     = 31;
    localparam int T_SHIFT = 30 - QB;
    localparam logic [QB:0] QSIZE = (QB + 1)'(1) << QB;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DONE     = 5'd1;
    localparam logic [4:0] S_TR_MUL   = 5'd2;
    localparam logic [4:0] S_TR_DIV1  = 5'd3;
    localparam logic [4:0] S_TR_MUL2  = 5'd4;
    localparam logic [4:0] S_TR_DIV2  = 5'd5;
    localparam logic [4:0] S_PH_MUL   = 5'd6;
    localparam logic [4:0] S_PH_DIV   = 5'd7;
    localparam logic [4:0] S_IX_DIV   = 5'd8;
    localparam logic [4:0] S_T2       = 5'd9;
    localparam logic [4:0] S_P9       = 5'd10;
    localparam logic [4:0] S_P7       = 5'd11;
    localparam logic [4:0] S_P5       = 5'd12;
    localparam logic [4:0] S_P3       = 5'd13;
    localparam logic [4:0] S_P1       = 5'd14;
    localparam logic [4:0] S_M1       = 5'd15;
    localparam logic [4:0] S_M2       = 5'd16;
    localparam logic [4:0] S_MDIV     = 5'd17;

    logic [4:0]  r_state, n_state;
    logic        r_shaking, n_shaking;
    logic [16:0] r_age, n_age;
    logic [15:0] r_peak, n_peak;
    logic [16:0] r_len, n_len;
    logic [7:0]  r_rate, n_rate;

    logic [1:0]     r_quad, n_quad;
    logic [T_W-1:0] r_t, n_t;
    logic [T_W-1:0] r_t2, n_t2;
    logic [16:0]    r_s16, n_s16;
    logic [16:0]    r_res_offset, n_res_offset;
    logic           r_res_active, n_res_active;
    logic           r_res_accepted, n_res_accepted;

    logic        r_out_valid, n_out_valid;
    logic [16:0] r_offset, n_offset;
    logic        r_active, n_active;
    logic        r_accepted, n_accepted;

    logic               w_mul_start;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic               w_mul_done;
    logic [MUL_P_W-1:0] w_mul_prod;
    logic               w_div_start;
    logic [DIV_N_W-1:0] w_div_num;
    logic [DIV_D_W-1:0] w_div_den;
    logic               w_div_done;
    logic [DIV_N_W-1:0] w_div_quot;
    logic [DIV_D_W-1:0] w_div_rem;

    logic [17:0]                w_age_sum;
    logic [16:0]                w_age_sat;
    logic [31:0]                w_q30;
    logic [31:0]                w_s30;
    logic [31:0]                w_s30_rnd;
    logic [SINE_PHASE_BITS-1:0] w_idx;
    logic [QB:0]                w_rq;
    logic [T_W-1:0]             w_t;
    logic [14:0]                w_periods;
    logic [16:0]                w_mag;

    dssg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    dssg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot),
        .o_rem   (w_div_rem)
    );

    assign w_age_sum = {1'b0, r_age} + 18'(i_delta_ms);
    assign w_age_sat = w_age_sum[17] ? AGE_MAX : w_age_sum[16:0];

    // Q2.30 product
    assign w_q30     = w_mul_prod[61:30];
    assign w_s30     = (w_q30 > Q30_ONE) ? Q30_ONE : w_q30;
    assign w_s30_rnd = w_s30 + 32'd8192;

    // mirror the quarter-wave argument in the 2nd and 4th quadrants
    assign w_idx = w_div_quot[SINE_PHASE_BITS-1:0];
    assign w_rq  = w_idx[QB] ? (QSIZE - {1'b0, w_idx[QB-1:0]}) : {1'b0, w_idx[QB-1:0]};
    assign w_t   = T_W'(w_rq) << T_SHIFT;

    assign w_periods = (w_div_quot == '0) ? 15'd1 : w_div_quot[14:0];
    assign w_mag     = w_div_quot[16:0];

    always_comb begin
        n_state        = r_state;
        n_shaking      = r_shaking;
        n_age          = r_age;
        n_peak         = r_peak;
        n_len          = r_len;
        n_rate         = r_rate;
        n_quad         = r_quad;
        n_t            = r_t;
        n_t2           = r_t2;
        n_s16          = r_s16;
        n_res_offset   = r_res_offset;
        n_res_active   = r_res_active;
        n_res_accepted = r_res_accepted;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_offset       = r_offset;
        n_active       = r_active;
        n_accepted     = r_accepted;
        w_mul_start    = 1'b0;
        w_mul_a        = '0;
        w_mul_b        = '0;
        w_div_start    = 1'b0;
        w_div_num      = '0;
        w_div_den      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_offset   = '0;
                    n_res_accepted = 1'b0;
                    n_res_active   = r_shaking;
                    if (i_opcode == OP_TRIGGER) begin
                        if (r_shaking || (i_amplitude == '0) || (i_duration_ms == '0)
                            || (i_frequency_hz == '0)) begin
                            n_state = S_DONE;
                        end else begin
                            n_peak      = i_amplitude;
                            n_rate      = i_frequency_hz;
                            w_mul_start = 1'b1;
                            w_mul_a     = MUL_A_W'(i_duration_ms);
                            w_mul_b     = MUL_B_W'(i_frequency_hz);
                            n_state     = S_TR_MUL;
                        end
                    end else if (!r_shaking) begin
                        n_state = S_DONE;
                    end else begin
                        n_age = w_age_sat;
                        if (w_age_sat > r_len) begin
                            n_shaking    = 1'b0;
                            n_res_active = 1'b0;
                            n_state      = S_DONE;
                        end else begin
                            w_mul_start = 1'b1;
                            w_mul_a     = MUL_A_W'(r_rate);
                            w_mul_b     = MUL_B_W'(w_age_sat);
                            n_state     = S_PH_MUL;
                        end
                    end
                end
            end
            S_TR_MUL: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = w_mul_prod[DIV_N_W-1:0];
                    w_div_den   = MS_PER_S;
                    n_state     = S_TR_DIV1;
                end
            end
            S_TR_DIV1: begin
                if (w_div_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_A_W'(w_periods);
                    w_mul_b     = MUL_B_W'(MS_PER_S);
                    n_state     = S_TR_MUL2;
                end
            end
            S_TR_MUL2: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = w_mul_prod[DIV_N_W-1:0];
                    w_div_den   = DIV_D_W'(r_rate);
                    n_state     = S_TR_DIV2;
                end
            end
            S_TR_DIV2: begin
                if (w_div_done) begin
                    n_len          = w_div_quot[16:0];
                    n_age          = '0;
                    n_shaking      = 1'b1;
                    n_res_offset   = '0;
                    n_res_active   = 1'b1;
                    n_res_accepted = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_PH_MUL: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = w_mul_prod[DIV_N_W-1:0];
                    w_div_den   = MS_PER_S;
                    n_state     = S_PH_DIV;
                end
            end
            S_PH_DIV: begin
                // remainder is the phase in thousandths of a period
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = DIV_N_W'(w_div_rem[9:0]) << SINE_PHASE_BITS;
                    w_div_den   = MS_PER_S;
                    n_state     = S_IX_DIV;
                end
            end
            S_IX_DIV: begin
                if (w_div_done) begin
                    n_quad      = w_idx[SINE_PHASE_BITS-1 -: 2];
                    n_t         = w_t;
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_A_W'(w_t);
                    w_mul_b     = MUL_B_W'(w_t);
                    n_state     = S_T2;
                end
            end
            S_T2: begin
                if (w_mul_done) begin
                    n_t2        = w_mul_prod[60:30];
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_A_W'(w_mul_prod[60:30]);
                    w_mul_b     = C9;
                    n_state     = S_P9;
                end
            end
            S_P9: begin
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_A_W'(r_t2);
                    w_mul_b     = C7 - w_q30;
                    n_state     = S_P7;
                end
            end
            S_P7: begin
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_A_W'(r_t2);
                    w_mul_b     = C5 - w_q30;
                    n_state     = S_P5;
                end
            end
            S_P5: begin
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_A_W'(r_t2);
                    w_mul_b     = C3 - w_q30;
                    n_state     = S_P3;
                end
            end
            S_P3: begin
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_A_W'(r_t);
                    w_mul_b     = C1 - w_q30;
                    n_state     = S_P1;
                end
            end
            S_P1: begin
                // clamp to one, round to Q16
                if (w_mul_done) begin
                    n_s16       = w_s30_rnd[30:14];
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_A_W'(r_peak);
                    w_mul_b     = MUL_B_W'(r_len - r_age);
                    n_state     = S_M1;
                end
            end
            S_M1: begin
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = MUL_A_W'(w_mul_prod[32:0]);
                    w_mul_b     = MUL_B_W'(r_s16);
                    n_state     = S_M2;
                end
            end
            S_M2: begin
                // dividing by length*2^16 equals dropping 16 bits then dividing by length
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = w_mul_prod[49:16];
                    w_div_den   = r_len;
                    n_state     = S_MDIV;
                end
            end
            S_MDIV: begin
                if (w_div_done) begin
                    n_res_offset   = r_quad[1] ? (~w_mag + 17'd1) : w_mag;
                    n_res_active   = 1'b1;
                    n_res_accepted = 1'b0;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_offset    = r_res_offset;
                    n_active    = r_res_active;
                    n_accepted  = r_res_accepted;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shaking   <= 1'b0;
            r_age       <= '0;
            r_peak      <= '0;
            r_len       <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_shaking   <= n_shaking;
            r_age       <= n_age;
            r_peak      <= n_peak;
            r_len       <= n_len;
            r_rate      <= n_rate;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quad         <= n_quad;
        r_t            <= n_t;
        r_t2           <= n_t2;
        r_s16          <= n_s16;
        r_res_offset   <= n_res_offset;
        r_res_active   <= n_res_active;
        r_res_accepted <= n_res_accepted;
        r_offset       <= n_offset;
        r_active       <= n_active;
        r_accepted     <= n_accepted;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_offset    = signed'(r_offset);
    assign o_active    = r_active;
    assign o_accepted  = r_accepted;

`ifndef SYNTHESIS
    a_started_is_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> o_active)
        else $error("started shake reported as inactive");

    a_idle_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_active) |-> (o_offset == 17'sd0))
        else $error("nonzero offset with no shake in progress");

    a_age_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && r_shaking) |-> ((r_age <= r_len) && (r_len != 17'd0)))
        else $error("shake in progress with age past its length");
`endif

endmodule

FILE: rtl/core/dssg_mul.sv
// ----------------------------------------------------------------------------
// dssg_mul
// Shift-and-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module dssg_mul
    import dssg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_A_W:0]   r_hi;
    logic [MUL_A_W:0]   w_sum;
    logic [MUL_B_W-1:0] r_lo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    // upper half never exceeds the multiplicand, so the sum fits one extra bit
    assign w_sum = r_hi + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MUL_B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= {1'b0, w_sum[MUL_A_W:1]};
            r_lo <= {w_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[MUL_A_W-1:0], r_lo};

endmodule

FILE: rtl/core/dssg_div.sv
// ----------------------------------------------------------------------------
// dssg_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module dssg_div
    import dssg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quot,
    output logic [DIV_D_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] r_num;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_D_W:0]   w_trial;
    logic [DIV_D_W:0]   w_diff;
    logic               w_ge;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    assign w_trial = {r_rem, r_num[DIV_N_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
            r_num <= {r_num[DIV_N_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule
